>>> src/dtl_pkg.sv
`default_nettype none

package dtl_pkg;

  localparam int TRANSITION_DEPTH = 1024;
  localparam int TYPE_DEPTH       = 256;

  localparam int TR_AW   = $clog2(TRANSITION_DEPTH);
  localparam int TY_AW   = $clog2(TYPE_DEPTH);
  localparam int CNT_W   = 11;
  localparam int TYCNT_W = 9;
  localparam int NCC_W   = 8;

  localparam int TIME_W  = 64;
  localparam int TREF_W  = 8;
  localparam int OFF_W   = 32;
  localparam int NAME_W  = 8;
  localparam int DELTA_W = 28;

  localparam int TR_W = TIME_W + TREF_W;
  localparam int TY_W = OFF_W + 1 + NAME_W;

  // divide by sixty as multiply by floor(2^37 / 60) plus one correction step
  localparam int          RECIP_SHIFT = 37;
  localparam logic [31:0] RECIP_60    = 32'h8888_8888;
  localparam int          DIVISOR     = 60;

  typedef enum logic [1:0] {
    CMD_LOAD_TRANS = 2'd0,
    CMD_LOAD_TYPE  = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_TRANS_COUNT = 2'd0,
    REG_TYPE_COUNT  = 2'd1,
    REG_NAME_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_STEP,
    ST_CMP,
    ST_GET_CUR,
    ST_GET_NXT,
    ST_GET_TNXT,
    ST_MUL,
    ST_CORR
  } state_t;

endpackage

`default_nettype wire

>>> src/dtl_ram.sv
`default_nettype none

module dtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/dst_transition_lookup.sv
`default_nettype none

// time-zone transition table with a dst query
//
// input channel: an item transfers at a rising edge with start high and busy
// low. in_command selects a transition load, a type load or a date query.
// loads are checked and written at the transfer edge; their result strobes
// on out_valid in the next cycle and busy never rises for them.
// a query holds busy while it bisects the transition table, one dependent
// read and one compare per halving, then reads both neighbor transitions
// and their types and scales the offset change to minutes.
// a query answers with range status straight from idle for an empty table,
// or after the first or last entry check for a date out of range; its run
// time is set by the single read port of the transition memory that every
// bisection step waits on.
// result channel: every result sits on the out_ ports for exactly one cycle
// with out_valid high; the receiver cannot stall it.
// configuration: cfg_we writes register cfg_index; write it only while idle,
// the block does not enforce that. reset clears the counts and the control
// state; table contents are undefined until loaded, no clearing pass runs.
module dst_transition_lookup
  import dtl_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [CNT_W-1:0]           cfg_wdata,

  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_command,
  input  wire logic [9:0]                 in_entry_index,
  input  wire logic signed [TIME_W-1:0]   in_time_value,
  input  wire logic [TREF_W-1:0]          in_type_ref,
  input  wire logic signed [OFF_W-1:0]    in_utc_offset,
  input  wire logic [7:0]                 in_dst_byte,
  input  wire logic [NAME_W-1:0]          in_name_index,

  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic signed [TIME_W-1:0]        out_current_switch,
  output logic [NAME_W-1:0]               out_current_name,
  output logic                            out_current_dst,
  output logic signed [TIME_W-1:0]        out_next_switch,
  output logic signed [DELTA_W-1:0]       out_delta_minutes,
  output logic [NAME_W-1:0]               out_next_name,
  output logic                            out_next_dst
);

  // configuration registers
  logic [CNT_W-1:0]   trans_count_r;
  logic [TYCNT_W-1:0] type_count_r;
  logic [NCC_W-1:0]   name_count_r;

  // control and search state
  state_t              state_r, state_nxt;
  logic [TIME_W-1:0]   tval_r, tval_nxt;
  logic [TR_AW-1:0]    last_r, last_nxt;
  logic [TR_AW-1:0]    lo_r, lo_nxt;
  logic [TR_AW-1:0]    hi_r, hi_nxt;

  // gathered neighbor data
  logic [TIME_W-1:0]   cur_time_r, cur_time_nxt;
  logic [TIME_W-1:0]   nxt_time_r, nxt_time_nxt;
  logic [OFF_W-1:0]    cur_off_r, cur_off_nxt;
  logic                cur_dst_r, cur_dst_nxt;
  logic [NAME_W-1:0]   cur_name_r, cur_name_nxt;
  logic                nxt_dst_r, nxt_dst_nxt;
  logic [NAME_W-1:0]   nxt_name_r, nxt_name_nxt;
  logic [OFF_W-1:0]    mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [63:0]         prod_r, prod_nxt;

  // result registers
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [TIME_W-1:0]   out_cur_sw_r;
  logic [NAME_W-1:0]   out_cur_name_r;
  logic                out_cur_dst_r;
  logic [TIME_W-1:0]   out_nxt_sw_r;
  logic [DELTA_W-1:0]  out_delta_r;
  logic [NAME_W-1:0]   out_nxt_name_r;
  logic                out_nxt_dst_r;

  // memory ports
  logic              tr_we, ty_we;
  logic [TR_AW-1:0]  tr_raddr;
  logic [TY_AW-1:0]  ty_raddr;
  logic [TR_W-1:0]   tr_rdata;
  logic [TY_W-1:0]   ty_rdata;

  // result request
  logic               res_fire;
  logic [1:0]         res_status;
  logic               res_full;
  logic [DELTA_W-1:0] res_delta;

  // decode of the offered item
  logic               accept;
  logic [CNT_W-1:0]   n_valid;
  logic [TYCNT_W-1:0] type_limit;
  logic               trans_bad, type_bad;
  logic               is_trans, is_type, is_query;

  // search helpers
  logic [TR_AW:0]     mid_sum;
  logic [TR_AW-1:0]   mid;
  logic               span_open;
  logic signed [TIME_W-1:0] rd_time;
  logic               below_rd;

  // divide-by-sixty correction
  logic [DELTA_W-2:0] q0;
  logic [OFF_W:0]     q0_x60;
  logic [OFF_W:0]     rem;
  logic [DELTA_W-1:0] q_mag;

  logic [OFF_W:0]     diff;

  assign accept   = start && !busy;
  assign is_trans = (in_command == CMD_LOAD_TRANS);
  assign is_type  = (in_command == CMD_LOAD_TYPE);
  assign is_query = (in_command == CMD_QUERY);

  assign n_valid    = (trans_count_r > CNT_W'(TRANSITION_DEPTH)) ?
                      CNT_W'(TRANSITION_DEPTH) : trans_count_r;
  assign type_limit = (type_count_r > TYCNT_W'(TYPE_DEPTH)) ?
                      TYCNT_W'(TYPE_DEPTH) : type_count_r;

  assign trans_bad = ({1'b0, in_type_ref} >= type_limit) ||
                     (int'(in_entry_index) >= TRANSITION_DEPTH);
  assign type_bad  = (in_dst_byte > 8'd1) || (in_name_index > name_count_r) ||
                     (int'(in_entry_index) >= TYPE_DEPTH);

  assign tr_we = accept && is_trans && !trans_bad;
  assign ty_we = accept && is_type && !type_bad;

  // bisection midpoint and the compare against the word just read
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[TR_AW:1];
  assign span_open = ({1'b0, lo_r} + 1'b1) < {1'b0, hi_r};
  assign rd_time   = $signed(tr_rdata[TR_W-1:TREF_W]);
  assign below_rd  = $signed(tval_r) < rd_time;

  // next offset minus current offset, 33 bits signed
  assign diff = {ty_rdata[TY_W-1], ty_rdata[TY_W-1:TY_W-OFF_W]} -
                {cur_off_r[OFF_W-1], cur_off_r};

  // quotient estimate is the true quotient or one below it
  assign q0     = prod_r[RECIP_SHIFT +: DELTA_W-1];
  assign q0_x60 = ((OFF_W+1)'(q0) << 6) - ((OFF_W+1)'(q0) << 2);
  assign rem    = {1'b0, mag_r} - q0_x60;
  assign q_mag  = (rem >= (OFF_W+1)'(DIVISOR)) ? ({1'b0, q0} + 1'b1) : {1'b0, q0};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query && (n_valid != '0)) begin
          state_nxt = ST_CHK_FIRST;
        end
      end
      ST_CHK_FIRST: begin
        state_nxt = below_rd ? ST_IDLE : ST_CHK_LAST;
      end
      ST_CHK_LAST: begin
        state_nxt = below_rd ? ST_STEP : ST_IDLE;
      end
      ST_STEP:     state_nxt = span_open ? ST_CMP : ST_GET_CUR;
      ST_CMP:      state_nxt = ST_STEP;
      ST_GET_CUR:  state_nxt = ST_GET_NXT;
      ST_GET_NXT:  state_nxt = ST_GET_TNXT;
      ST_GET_TNXT: state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_CORR;
      ST_CORR:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory addresses and result requests
  always_comb begin
    tr_raddr   = '0;
    ty_raddr   = tr_rdata[TY_AW-1:0];
    res_fire   = 1'b0;
    res_status = STAT_OK;
    res_full   = 1'b0;
    res_delta  = neg_r ? (DELTA_W'(0) - q_mag) : q_mag;
    case (state_r)
      ST_IDLE: begin
        tr_raddr = '0;
        if (accept) begin
          if (is_trans) begin
            res_fire   = 1'b1;
            res_status = trans_bad ? STAT_BAD : STAT_OK;
          end else if (is_type) begin
            res_fire   = 1'b1;
            res_status = type_bad ? STAT_BAD : STAT_OK;
          end else if (is_query) begin
            if (n_valid == '0) begin
              res_fire   = 1'b1;
              res_status = STAT_RANGE;
            end
          end else begin
            res_fire   = 1'b1;
            res_status = STAT_BAD;
          end
        end
      end
      ST_CHK_FIRST: begin
        tr_raddr = last_r;
        if (below_rd) begin
          res_fire   = 1'b1;
          res_status = STAT_RANGE;
        end
      end
      ST_CHK_LAST: begin
        if (!below_rd) begin
          res_fire   = 1'b1;
          res_status = STAT_RANGE;
        end
      end
      ST_STEP:    tr_raddr = span_open ? mid : (hi_r - 1'b1);
      ST_GET_CUR: tr_raddr = hi_r;
      ST_CORR: begin
        res_fire = 1'b1;
        res_full = 1'b1;
      end
      default: begin
        tr_raddr = '0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    tval_nxt     = tval_r;
    last_nxt     = last_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    cur_time_nxt = cur_time_r;
    nxt_time_nxt = nxt_time_r;
    cur_off_nxt  = cur_off_r;
    cur_dst_nxt  = cur_dst_r;
    cur_name_nxt = cur_name_r;
    nxt_dst_nxt  = nxt_dst_r;
    nxt_name_nxt = nxt_name_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    prod_nxt     = prod_r;
    case (state_r)
      ST_IDLE: begin
        tval_nxt = in_time_value;
        last_nxt = TR_AW'(n_valid - 1'b1);
      end
      ST_CHK_LAST: begin
        lo_nxt = '0;
        hi_nxt = last_r;
      end
      ST_CMP: begin
        if (below_rd) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid;
        end
      end
      ST_GET_CUR: begin
        cur_time_nxt = tr_rdata[TR_W-1:TREF_W];
      end
      ST_GET_NXT: begin
        nxt_time_nxt = tr_rdata[TR_W-1:TREF_W];
        cur_off_nxt  = ty_rdata[TY_W-1:TY_W-OFF_W];
        cur_dst_nxt  = ty_rdata[NAME_W];
        cur_name_nxt = ty_rdata[NAME_W-1:0];
      end
      ST_GET_TNXT: begin
        nxt_dst_nxt  = ty_rdata[NAME_W];
        nxt_name_nxt = ty_rdata[NAME_W-1:0];
        neg_nxt      = diff[OFF_W];
        mag_nxt      = diff[OFF_W] ? OFF_W'(-diff) : diff[OFF_W-1:0];
      end
      ST_MUL: begin
        prod_nxt = 64'(mag_r) * 64'(RECIP_60);
      end
      default: begin
        tval_nxt = tval_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      trans_count_r <= '0;
      type_count_r  <= '0;
      name_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_fire;
      if (cfg_we) begin
        case (cfg_index)
          REG_TRANS_COUNT: trans_count_r <= cfg_wdata;
          REG_TYPE_COUNT:  type_count_r  <= cfg_wdata[TYCNT_W-1:0];
          REG_NAME_COUNT:  name_count_r  <= cfg_wdata[NCC_W-1:0];
          default: begin
            name_count_r <= name_count_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tval_r     <= tval_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_time_r <= cur_time_nxt;
    nxt_time_r <= nxt_time_nxt;
    cur_off_r  <= cur_off_nxt;
    cur_dst_r  <= cur_dst_nxt;
    cur_name_r <= cur_name_nxt;
    nxt_dst_r  <= nxt_dst_nxt;
    nxt_name_r <= nxt_name_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    if (res_fire) begin
      // fields other than status stay zero unless a query succeeds
      out_status_r   <= res_status;
      out_cur_sw_r   <= res_full ? cur_time_r : '0;
      out_cur_name_r <= res_full ? cur_name_r : '0;
      out_cur_dst_r  <= res_full && cur_dst_r;
      out_nxt_sw_r   <= res_full ? nxt_time_r : '0;
      out_delta_r    <= res_full ? res_delta : '0;
      out_nxt_name_r <= res_full ? nxt_name_r : '0;
      out_nxt_dst_r  <= res_full && nxt_dst_r;
    end
  end

  // transition table: time in the upper bits, type reference below
  dtl_ram #(
    .WIDTH (TR_W),
    .DEPTH (TRANSITION_DEPTH)
  ) u_trans_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (in_entry_index[TR_AW-1:0]),
    .wdata ({in_time_value, in_type_ref}),
    .raddr (tr_raddr),
    .rdata (tr_rdata)
  );

  // type table: offset, dst flag, name index
  dtl_ram #(
    .WIDTH (TY_W),
    .DEPTH (TYPE_DEPTH)
  ) u_type_ram (
    .clk   (clk),
    .we    (ty_we),
    .waddr (in_entry_index[TY_AW-1:0]),
    .wdata ({in_utc_offset, in_dst_byte[0], in_name_index}),
    .raddr (ty_raddr),
    .rdata (ty_rdata)
  );

  // loads only write while idle, so a query never reads an entry in flight
  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_current_switch = out_cur_sw_r;
  assign out_current_name   = out_cur_name_r;
  assign out_current_dst    = out_cur_dst_r;
  assign out_next_switch    = out_nxt_sw_r;
  assign out_delta_minutes  = out_delta_r;
  assign out_next_name      = out_nxt_name_r;
  assign out_next_dst       = out_nxt_dst_r;

  // table writes happen only at an idle transfer
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tr_we || ty_we) |-> (state_r == ST_IDLE))
    else $error("table write outside idle");

  // the bisection window never collapses
  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP || state_r == ST_CMP) |-> (lo_r < hi_r))
    else $error("search window empty");

  // the final step always delivers a successful result
  a_corr_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORR) |=> (out_valid_r && out_status_r == STAT_OK))
    else $error("missing query result");

  // failed results carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |->
      (out_cur_sw_r == '0 && out_nxt_sw_r == '0 && out_delta_r == '0))
    else $error("payload on failed result");

  // the estimate leaves a remainder below twice the divisor
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORR) |-> (rem < (OFF_W+1)'(2 * DIVISOR)))
    else $error("reciprocal estimate off by more than one");

endmodule

`default_nettype wire

>>> sim/dtl_checker.sv
`timescale 1ns / 1ps

module dtl_checker
  import dtl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [CNT_W-1:0]          cfg_wdata,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                in_command,
  input  logic [9:0]                in_entry_index,
  input  logic signed [TIME_W-1:0]  in_time_value,
  input  logic [TREF_W-1:0]         in_type_ref,
  input  logic signed [OFF_W-1:0]   in_utc_offset,
  input  logic [7:0]                in_dst_byte,
  input  logic [NAME_W-1:0]         in_name_index,
  input  logic                      out_valid,
  input  logic [1:0]                out_status,
  input  logic signed [TIME_W-1:0]  out_current_switch,
  input  logic [NAME_W-1:0]         out_current_name,
  input  logic                      out_current_dst,
  input  logic signed [TIME_W-1:0]  out_next_switch,
  input  logic signed [DELTA_W-1:0] out_delta_minutes,
  input  logic [NAME_W-1:0]         out_next_name,
  input  logic                      out_next_dst,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int SECS_PER_MIN = 60;

  typedef struct packed {
    logic [1:0]          status;
    logic [TIME_W-1:0]   cur_switch;
    logic [NAME_W-1:0]   cur_name;
    logic                cur_dst;
    logic [TIME_W-1:0]   nxt_switch;
    logic [DELTA_W-1:0]  delta;
    logic [NAME_W-1:0]   nxt_name;
    logic                nxt_dst;
  } zone_answer_t;

  // shadow of the block's tables and counts
  bit signed [TIME_W-1:0] sw_time   [TRANSITION_DEPTH];
  bit [TREF_W-1:0]        sw_type   [TRANSITION_DEPTH];
  bit signed [OFF_W-1:0]  ty_offset [TYPE_DEPTH];
  bit                     ty_dst    [TYPE_DEPTH];
  bit [NAME_W-1:0]        ty_name   [TYPE_DEPTH];
  bit [CNT_W-1:0]         n_transitions;
  bit [TYCNT_W-1:0]       n_types;
  bit [NCC_W-1:0]         n_name_chars;

  zone_answer_t answers[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic zone_answer_t resolve(logic [1:0] cmd, logic [9:0] slot,
                                           logic signed [TIME_W-1:0] tv,
                                           logic [TREF_W-1:0] tref,
                                           logic signed [OFF_W-1:0] off,
                                           logic [7:0] dstb, logic [NAME_W-1:0] nidx);
    zone_answer_t r;
    int type_lim;
    int n;
    int lo;
    int hi;
    int mid;
    int cur;
    int nxt;
    longint diff;
    r = '0;
    case (cmd_t'(cmd))
      CMD_LOAD_TRANS: begin
        type_lim = (int'(n_types) < TYPE_DEPTH) ? int'(n_types) : TYPE_DEPTH;
        if (int'(tref) >= type_lim || int'(slot) >= TRANSITION_DEPTH) begin
          r.status = STAT_BAD;
        end else begin
          sw_time[slot] = tv;
          sw_type[slot] = tref;
        end
      end
      CMD_LOAD_TYPE: begin
        if (dstb > 8'd1 || nidx > n_name_chars || int'(slot) >= TYPE_DEPTH) begin
          r.status = STAT_BAD;
        end else begin
          ty_offset[slot[TY_AW-1:0]] = off;
          ty_dst[slot[TY_AW-1:0]]    = dstb[0];
          ty_name[slot[TY_AW-1:0]]   = nidx;
        end
      end
      CMD_QUERY: begin
        n = (int'(n_transitions) < TRANSITION_DEPTH) ? int'(n_transitions) : TRANSITION_DEPTH;
        if (n == 0 || tv < sw_time[0] || tv >= sw_time[n-1]) begin
          r.status = STAT_RANGE;
        end else begin
          // bisect until hi is the first entry above the date
          lo = 0;
          hi = n - 1;
          while (lo + 1 < hi) begin
            mid = (lo + hi) / 2;
            if (tv < sw_time[mid]) hi = mid;
            else lo = mid;
          end
          cur  = int'(sw_type[hi-1]);
          nxt  = int'(sw_type[hi]);
          diff = (longint'(ty_offset[nxt]) - longint'(ty_offset[cur])) / SECS_PER_MIN;
          r.status     = STAT_OK;
          r.cur_switch = sw_time[hi-1];
          r.cur_name   = ty_name[cur];
          r.cur_dst    = ty_dst[cur];
          r.nxt_switch = sw_time[hi];
          r.delta      = diff[DELTA_W-1:0];
          r.nxt_name   = ty_name[nxt];
          r.nxt_dst    = ty_dst[nxt];
        end
      end
      default: r.status = STAT_BAD;
    endcase
    return r;
  endfunction

  task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    zone_answer_t want;
    if (!rst_n) begin
      n_transitions = '0;
      n_types       = '0;
      n_name_chars  = '0;
      answers.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_TRANS_COUNT: n_transitions = cfg_wdata[CNT_W-1:0];
          REG_TYPE_COUNT:  n_types       = cfg_wdata[TYCNT_W-1:0];
          REG_NAME_COUNT:  n_name_chars  = cfg_wdata[NCC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (answers.size() == 0) begin
          $error("status: expected no result, got %0d", out_status);
          mismatches++;
        end else begin
          want = answers.pop_front();
          check_field("status", want.status, out_status);
          check_field("current_switch", $signed(want.cur_switch), out_current_switch);
          check_field("current_name", want.cur_name, out_current_name);
          check_field("current_dst", want.cur_dst, out_current_dst);
          check_field("next_switch", $signed(want.nxt_switch), out_next_switch);
          check_field("delta_minutes", $signed(want.delta), out_delta_minutes);
          check_field("next_name", want.nxt_name, out_next_name);
          check_field("next_dst", want.nxt_dst, out_next_dst);
        end
      end
      if (start && !busy) begin
        answers.push_back(resolve(in_command, in_entry_index, in_time_value, in_type_ref,
                                  in_utc_offset, in_dst_byte, in_name_index));
      end
    end
    outstanding <= answers.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb
  import dtl_pkg::*;
;

  // cycles with no transfer, no result and no config write before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // drain time after the last result, above the longest query latency
  localparam int TAIL_CYCLES    = 64;

  localparam logic [63:0] TIME_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] OFF_MIN  = 32'h8000_0000;
  localparam logic [31:0] OFF_MAX  = 32'h7FFF_FFFF;

  logic                      clk;
  logic                      rst_n              = 1'b0;
  logic                      cfg_we             = 1'b0;
  logic [1:0]                cfg_index          = '0;
  logic [CNT_W-1:0]          cfg_wdata          = '0;
  logic                      start              = 1'b0;
  logic                      busy;
  logic [1:0]                in_command         = '0;
  logic [9:0]                in_entry_index     = '0;
  logic signed [TIME_W-1:0]  in_time_value      = '0;
  logic [TREF_W-1:0]         in_type_ref        = '0;
  logic signed [OFF_W-1:0]   in_utc_offset      = '0;
  logic [7:0]                in_dst_byte        = '0;
  logic [NAME_W-1:0]         in_name_index      = '0;
  logic                      out_valid;
  logic [1:0]                out_status;
  logic signed [TIME_W-1:0]  out_current_switch;
  logic [NAME_W-1:0]         out_current_name;
  logic                      out_current_dst;
  logic signed [TIME_W-1:0]  out_next_switch;
  logic signed [DELTA_W-1:0] out_delta_minutes;
  logic [NAME_W-1:0]         out_next_name;
  logic                      out_next_dst;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;

  // stimulus-side bookkeeping: which slots hold good data, so that a query
  // never lands on a table entry or a type that was never loaded
  bit signed [63:0] sw_plan   [TRANSITION_DEPTH];
  bit               ty_loaded [TYPE_DEPTH];
  int               rows_ready = 0;   // entries 0..rows_ready-1 are loaded
  int               tc_now     = 0;
  int               tyc_now    = 0;
  int               ncc_now    = 0;
  bit               gaps_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  dst_transition_lookup dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_entry_index     (in_entry_index),
    .in_time_value      (in_time_value),
    .in_type_ref        (in_type_ref),
    .in_utc_offset      (in_utc_offset),
    .in_dst_byte        (in_dst_byte),
    .in_name_index      (in_name_index),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_current_switch (out_current_switch),
    .out_current_name   (out_current_name),
    .out_current_dst    (out_current_dst),
    .out_next_switch    (out_next_switch),
    .out_delta_minutes  (out_delta_minutes),
    .out_next_name      (out_next_name),
    .out_next_dst       (out_next_dst)
  );

  dtl_checker answer_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_entry_index     (in_entry_index),
    .in_time_value      (in_time_value),
    .in_type_ref        (in_type_ref),
    .in_utc_offset      (in_utc_offset),
    .in_dst_byte        (in_dst_byte),
    .in_name_index      (in_name_index),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_current_switch (out_current_switch),
    .out_current_name   (out_current_name),
    .out_current_dst    (out_current_dst),
    .out_next_switch    (out_next_switch),
    .out_delta_minutes  (out_delta_minutes),
    .out_next_name      (out_next_name),
    .out_next_dst       (out_next_dst),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // watchdog: any transfer, result or register write counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // offsets lean on the extremes now and then
  function automatic logic [31:0] rand_offset();
    case ($urandom_range(0, 7))
      0:       return OFF_MIN;
      1:       return OFF_MAX;
      2:       return 32'($signed($urandom_range(0, 7200)) - 3600);
      default: return $urandom;
    endcase
  endfunction

  // one transfer; start stays high afterwards unless a gap follows
  task automatic send(cmd_t cmd, int slot, logic [63:0] tv, int tref, logic [31:0] off,
                      int dstb, int nidx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_entry_index <= 10'(slot);
    in_time_value  <= tv;
    in_type_ref    <= 8'(tref);
    in_utc_offset  <= off;
    in_dst_byte    <= 8'(dstb);
    in_name_index  <= 8'(nidx);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_type(int slot, logic [31:0] off, int dstb, int nidx);
    send(CMD_LOAD_TYPE, slot, rand64(), $urandom_range(0, 255), off, dstb, nidx);
    if (slot < TYPE_DEPTH && dstb <= 1 && nidx <= ncc_now) ty_loaded[slot] = 1'b1;
  endtask

  task automatic load_trans(int slot, logic [63:0] tv, int tref);
    int lim;
    lim = (tyc_now < TYPE_DEPTH) ? tyc_now : TYPE_DEPTH;
    send(CMD_LOAD_TRANS, slot, tv, tref, $urandom, $urandom_range(0, 255),
         $urandom_range(0, 255));
    if (tref < lim && slot < TRANSITION_DEPTH) sw_plan[slot] = tv;
  endtask

  task automatic query(logic [63:0] tv);
    send(CMD_QUERY, $urandom_range(0, 1023), tv, $urandom_range(0, 255), $urandom,
         $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // hold off until every expected result has come back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  // all three registers, back to back, only with the block idle
  task automatic set_counts(int tc, int tyc, int ncc);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TRANS_COUNT;
    cfg_wdata <= CNT_W'(tc);
    @(posedge clk);
    cfg_index <= REG_TYPE_COUNT;
    cfg_wdata <= CNT_W'(tyc);
    @(posedge clk);
    cfg_index <= REG_NAME_COUNT;
    cfg_wdata <= CNT_W'(ncc);
    @(posedge clk);
    cfg_we  <= 1'b0;
    tc_now  = tc;
    tyc_now = tyc;
    ncc_now = ncc;
  endtask

  // a loaded type below the type limit, or -1 if there is none
  function automatic int pick_type(int lim);
    int picks[$];
    for (int t = 0; t < lim; t++) begin
      if (ty_loaded[t]) picks.push_back(t);
    end
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(0, picks.size() - 1)];
  endfunction

  // dates near the loaded transitions: exact hits, one off either way,
  // around both ends of the span, inside the span, or anywhere at all
  function automatic logic [63:0] pick_date(int n);
    int i;
    logic [63:0] span;
    if (n == 0) return rand64();
    i = $urandom_range(0, n - 1);
    span = sw_plan[n-1] - sw_plan[0];
    case ($urandom_range(0, 7))
      0:       return sw_plan[i];
      1:       return sw_plan[i] - 64'd1;
      2:       return sw_plan[i] + 64'd1;
      3:       return sw_plan[0] - 64'($urandom_range(0, 2));
      4:       return sw_plan[n-1] - 64'd1 + 64'($urandom_range(0, 2));
      5, 6:    return (span == 0) ? sw_plan[0] : sw_plan[0] + rand64() % span;
      default: return rand64();
    endcase
  endfunction

  // style 0: strictly rising over the whole 64-bit range
  // style 1: clustered with small steps, repeats allowed
  // otherwise: unsorted, with many small colliding values
  task automatic fill_table(int n, int style, int lim);
    bit [63:0] t;
    bit [63:0] step;
    step = 64'hFFFF_FFFF_FFFF_FFFF / 64'(n);
    t    = rand64();
    for (int i = 0; i < n; i++) begin
      if (style == 0) begin
        t = TIME_MIN + 64'(i) * step + rand64() % step;
      end else if (style == 1) begin
        if (i > 0) t = t + 64'($urandom_range(0, 5000));
      end else begin
        t = ($urandom_range(0, 1) == 0) ? rand64() : 64'($urandom_range(0, 20));
      end
      load_trans(i, t, pick_type(lim));
    end
    if (n > rows_ready) rows_ready = n;
  endtask

  // a load or command that the block must refuse
  task automatic bad_item(int lim);
    case ($urandom_range(0, 4))
      0: begin
        if (lim < TYPE_DEPTH) load_trans($urandom_range(0, 1023), rand64(),
                                         $urandom_range(lim, 255));
        else send(CMD_UNUSED, $urandom_range(0, 1023), rand64(), $urandom_range(0, 255),
                  $urandom, $urandom_range(0, 255), $urandom_range(0, 255));
      end
      1: load_type($urandom_range(0, 255), rand_offset(), $urandom_range(2, 255),
                   $urandom_range(0, ncc_now));
      2: begin
        if (ncc_now < 255) load_type($urandom_range(0, 255), rand_offset(),
                                     $urandom_range(0, 1), $urandom_range(ncc_now + 1, 255));
        else load_type($urandom_range(0, 255), rand_offset(), $urandom_range(2, 255), 0);
      end
      3: load_type($urandom_range(TYPE_DEPTH, 1023), rand_offset(), $urandom_range(0, 1),
                   $urandom_range(0, ncc_now));
      default: send(CMD_UNUSED, $urandom_range(0, 1023), rand64(), $urandom_range(0, 255),
                    $urandom, $urandom_range(0, 255), $urandom_range(0, 255));
    endcase
  endtask

  // mostly queries, with loads that keep the table well formed and a share
  // of refused items in between
  task automatic run_mix(int items, int lim, int n_eff);
    int r;
    int slot;
    int tref;
    bit ready;
    ready = (n_eff <= rows_ready);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if (ready) query(pick_date(n_eff));
        else bad_item(lim);
      end else if (r < 70) begin
        tref = pick_type(lim);
        if (tref < 0) begin
          bad_item(lim);
        end else if (n_eff > 0 && $urandom_range(0, 9) < 7) begin
          // same time, new type; now and then a fresh time that unsorts it
          slot = $urandom_range(0, n_eff - 1);
          load_trans(slot, ($urandom_range(0, 3) == 0) ? rand64() : sw_plan[slot], tref);
        end else begin
          load_trans($urandom_range(0, 1023), rand64(), tref);
        end
      end else if (r < 80) begin
        slot = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 255);
        load_type(slot, rand_offset(), $urandom_range(0, 1), $urandom_range(0, ncc_now));
      end else begin
        bad_item(lim);
      end
      // sender pauses for the block to run dry now and then
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  // style < 0 keeps the table from an earlier phase
  task automatic run_phase(int tc, int tyc, int ncc, int style, int items);
    int lim;
    int n_eff;
    set_counts(tc, tyc, ncc);
    lim   = (tyc < TYPE_DEPTH) ? tyc : TYPE_DEPTH;
    n_eff = (tc < TRANSITION_DEPTH) ? tc : TRANSITION_DEPTH;
    if (lim > 0) begin
      load_type(0, rand_offset(), $urandom_range(0, 1), $urandom_range(0, ncc));
      repeat ($urandom_range(1, 6)) begin
        load_type($urandom_range(0, lim - 1), rand_offset(), $urandom_range(0, 1),
                  $urandom_range(0, ncc));
      end
      if (lim == TYPE_DEPTH) load_type(TYPE_DEPTH - 1, rand_offset(), 1, ncc);
      if (n_eff > 0 && style >= 0) fill_table(n_eff, style, lim);
    end
    run_mix(items, lim, n_eff);
  endtask

  // short directed pass over the corners
  task automatic directed();
    // empty table after reset, then a load against a zero type count
    query(rand64());
    load_trans(5, rand64(), 0);
    set_counts(3, 2, 255);
    // offset extremes give the largest minute swing both ways
    load_type(0, OFF_MIN, 0, 0);
    load_type(1, OFF_MAX, 1, 255);
    // dst byte above one, type slot past the type store
    load_type(2, rand_offset(), 2, 3);
    load_type(3, rand_offset(), 255, 0);
    load_type(TYPE_DEPTH, rand_offset(), 0, 0);
    load_type(1023, rand_offset(), 1, 1);
    // three entries spanning the full time range
    load_trans(0, TIME_MIN, 0);
    load_trans(1, 64'd0, 1);
    load_trans(2, TIME_MAX, 0);
    rows_ready = 3;
    // type references at and past the type count
    load_trans(1, 64'd7, 2);
    load_trans(2, 64'd7, 255);
    query(TIME_MIN);
    query(64'hFFFF_FFFF_FFFF_FFFF);
    query(64'd0);
    query(TIME_MAX - 64'd1);
    query(TIME_MAX);
    send(CMD_UNUSED, 1023, TIME_MAX, 255, OFF_MAX, 255, 255);
    // name index just past and at the name store size
    set_counts(3, 2, 10);
    load_type(2, -32'sd59, 0, 11);
    load_type(2, -32'sd59, 1, 10);
    // a single entry never brackets a date
    set_counts(1, 2, 10);
    query(64'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();

    // fixed corners of the register space
    run_phase(2, 1, 0, 0, 50);
    run_phase(17, 256, 255, 0, 60);
    run_phase(64, 8, 100, 1, 60);
    run_phase(5, 511, 37, 0, 50);
    run_phase(0, 0, 0, 0, 40);
    run_phase(300, 3, 200, 2, 60);

    // a stretch with no random gaps between transfers
    gaps_on = 1'b0;
    run_phase(40, 16, 255, 1, 40);
    gaps_on = 1'b1;

    // full table, then counts past the table depth on the same contents
    run_phase(1024, 256, 255, 0, 50);
    run_phase(2047, 128, 64, -1, 40);
    run_phase(1025, 300, 254, -1, 30);

    // small random tables
    repeat (6) begin
      run_phase($urandom_range(2, 40), $urandom_range(1, 300), $urandom_range(0, 255),
                $urandom_range(0, 2), 50);
    end

    // closing part without random gaps
    gaps_on = 1'b0;
    run_phase(33, 64, 255, 0, 100);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
